### rtl/ncf_pkg.sv
// Shared types and constants for the nearest centre finder.
`timescale 1ns / 1ps

package ncf_pkg;

  localparam int NUM_GROUPS = 8;
  localparam int GROUP_W    = 3;
  localparam int THRESH_W   = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int TAG_IDX_W  = 8;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESH_D1_PRI = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_D1_SEC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_D2_PRI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_D2_SEC = 3'd3;

  localparam logic [THRESH_W-1:0] THRESH_D1_PRI_RST = 40'd10504448;
  localparam logic [THRESH_W-1:0] THRESH_D1_SEC_RST = 40'd7862272;
  localparam logic [THRESH_W-1:0] THRESH_D2_PRI_RST = 40'd12657152;
  localparam logic [THRESH_W-1:0] THRESH_D2_SEC_RST = 40'd9387776;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_FOUND = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_RD,
    ST_CHK_WAIT,
    ST_SCAN,
    ST_RESULT
  } ctrl_state_t;

  // Travels with each centre read through the memory and distance pipeline.
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic [TAG_IDX_W-1:0] idx;
  } rd_tag_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 from_cache;
  } result_t;

endpackage

### rtl/ncf_centre_mem.sv
// Centre store: single write port, registered read port with tag.
`timescale 1ns / 1ps

module ncf_centre_mem #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9,
  parameter int DATA_W = 60
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [DATA_W-1:0]   wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  input  ncf_pkg::rd_tag_t    tag_in,
  input  logic                flush,
  output logic [DATA_W-1:0]   rdata,
  output ncf_pkg::rd_tag_t    tag_out
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      tag_out <= '0;
    end else begin
      tag_out.vld  <= tag_in.vld && re;
      tag_out.last <= tag_in.last;
      tag_out.idx  <= tag_in.idx;
    end
  end

endmodule

### rtl/ncf_dist.sv
// Two-stage squared distance pipeline between a stored centre and the query point.
`timescale 1ns / 1ps

module ncf_dist #(
  parameter int COORD_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [3*COORD_BITS-1:0]     centre,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  input  ncf_pkg::rd_tag_t            tag_in,
  input  logic                        flush,
  output logic [2*COORD_BITS+3:0]     sq_dist,
  output ncf_pkg::rd_tag_t            tag_out
);

  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int DIST_W = SQ_W + 2;

  logic signed [COORD_BITS:0]  dx, dy, dz;
  logic signed [SQ_W-1:0]      mx, my, mz;
  logic [SQ_W-1:0]             sqx, sqy, sqz;
  ncf_pkg::rd_tag_t            tag_sq;

  always_comb begin
    dx = $signed({px[COORD_BITS-1], px})
       - $signed({centre[COORD_BITS-1], centre[COORD_BITS-1:0]});
    dy = $signed({py[COORD_BITS-1], py})
       - $signed({centre[2*COORD_BITS-1], centre[2*COORD_BITS-1:COORD_BITS]});
    dz = $signed({pz[COORD_BITS-1], pz})
       - $signed({centre[3*COORD_BITS-1], centre[3*COORD_BITS-1:2*COORD_BITS]});
    mx = dx * dx;
    my = dy * dy;
    mz = dz * dz;
  end

  always_ff @(posedge clk) begin
    sqx     <= $unsigned(mx);
    sqy     <= $unsigned(my);
    sqz     <= $unsigned(mz);
    sq_dist <= DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      tag_sq  <= '0;
      tag_out <= '0;
    end else begin
      tag_sq  <= tag_in;
      tag_out <= tag_sq;
    end
  end

endmodule

### rtl/ncf_ctrl.sv
// Command sequencer: group bookkeeping, thresholds, cache check and linear scan.
`timescale 1ns / 1ps

module ncf_ctrl #(
  parameter int ENTRIES_PER_GROUP = 64,
  parameter int COORD_BITS        = 20
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ncf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ncf_pkg::THRESH_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic [ncf_pkg::GROUP_W-1:0]          in_group,
  input  logic signed [COORD_BITS-1:0]         in_x,
  input  logic signed [COORD_BITS-1:0]         in_y,
  input  logic signed [COORD_BITS-1:0]         in_z,
  output logic                                 mem_we,
  output logic [$clog2(8*ENTRIES_PER_GROUP)-1:0] mem_waddr,
  output logic [3*COORD_BITS-1:0]              mem_wdata,
  output logic                                 mem_re,
  output logic [$clog2(8*ENTRIES_PER_GROUP)-1:0] mem_raddr,
  output ncf_pkg::rd_tag_t                     mem_tag,
  output logic                                 flush,
  output logic signed [COORD_BITS-1:0]         px,
  output logic signed [COORD_BITS-1:0]         py,
  output logic signed [COORD_BITS-1:0]         pz,
  input  logic [2*COORD_BITS+3:0]              sq_dist,
  input  ncf_pkg::rd_tag_t                     dist_tag,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output ncf_pkg::result_t                     res
);

  localparam int ADDR_W = $clog2(8 * ENTRIES_PER_GROUP);
  localparam int IDX_W  = (ENTRIES_PER_GROUP > 1) ? $clog2(ENTRIES_PER_GROUP) : 1;
  localparam int CNT_W  = $clog2(ENTRIES_PER_GROUP + 1);
  localparam int DIST_W = 2 * COORD_BITS + 4;
  localparam int CMP_W  = (DIST_W > ncf_pkg::THRESH_W) ? DIST_W : ncf_pkg::THRESH_W;
  localparam int OUT_IDX_PAD = ncf_pkg::OUT_IDX_W;

  ncf_pkg::ctrl_state_t state, state_next;

  logic [ncf_pkg::THRESH_W-1:0] thresh [4];
  logic [CNT_W-1:0]             count [ncf_pkg::NUM_GROUPS];
  logic [IDX_W-1:0]             last_idx [ncf_pkg::NUM_GROUPS];
  logic                         last_vld [ncf_pkg::NUM_GROUPS];

  logic [ncf_pkg::GROUP_W-1:0]  grp;
  logic [CNT_W-1:0]             n_reg;
  logic [CNT_W-1:0]             iss;
  logic                         have;
  logic [DIST_W-1:0]            best;
  logic [IDX_W-1:0]             idx_r;
  logic                         cached_r;
  ncf_pkg::status_t             status_r;

  logic                         accept;
  logic                         in_full;
  logic                         in_hit;
  logic [CMP_W-1:0]             d_ext, lim_ext, best_ext;
  logic                         better, stop, finish, chk_ok;
  logic [IDX_W-1:0]             tag_idx, idx_final;
  logic [IDX_W+OUT_IDX_PAD-1:0] idx_wide;

  function automatic logic [ADDR_W-1:0] slot(input logic [ncf_pkg::GROUP_W-1:0] g,
                                             input logic [IDX_W-1:0] i);
    return ADDR_W'(g) * ADDR_W'(ENTRIES_PER_GROUP) + ADDR_W'(i);
  endfunction

  always_comb begin
    accept    = (state == ncf_pkg::ST_IDLE) && in_valid;
    in_full   = (count[in_group] == CNT_W'(ENTRIES_PER_GROUP));
    in_hit    = last_vld[in_group] && (CNT_W'(last_idx[in_group]) < count[in_group]);
    mem_we    = accept && (in_cmd == ncf_pkg::CMD_APPEND) && !in_full;
    mem_waddr = slot(in_group, count[in_group][IDX_W-1:0]);
    mem_wdata = {in_z, in_y, in_x};

    d_ext     = CMP_W'(sq_dist);
    lim_ext   = CMP_W'(thresh[{grp[2], grp[0]}]);
    best_ext  = CMP_W'(best);
    tag_idx   = dist_tag.idx[IDX_W-1:0];
    chk_ok    = d_ext <= lim_ext;
    better    = !have || (d_ext < best_ext);
    stop      = better && (d_ext < lim_ext);
    finish    = 1'b0;
    idx_final = better ? tag_idx : idx_r;
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = slot(grp, last_idx[grp]);
    mem_tag    = '0;
    flush      = 1'b0;
    res_valid  = 1'b0;
    case (state)
      ncf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if ((in_cmd == ncf_pkg::CMD_QUERY) && (count[in_group] != '0)) begin
            state_next = in_hit ? ncf_pkg::ST_CHK_RD : ncf_pkg::ST_SCAN;
          end else begin
            state_next = ncf_pkg::ST_RESULT;
          end
        end
      end
      ncf_pkg::ST_CHK_RD: begin
        mem_re       = 1'b1;
        mem_tag.vld  = 1'b1;
        mem_tag.last = 1'b1;
        mem_tag.idx  = ncf_pkg::TAG_IDX_W'(last_idx[grp]);
        state_next   = ncf_pkg::ST_CHK_WAIT;
      end
      ncf_pkg::ST_CHK_WAIT: begin
        if (dist_tag.vld) begin
          state_next = chk_ok ? ncf_pkg::ST_RESULT : ncf_pkg::ST_SCAN;
        end
      end
      ncf_pkg::ST_SCAN: begin
        mem_raddr    = slot(grp, iss[IDX_W-1:0]);
        mem_re       = iss < n_reg;
        mem_tag.vld  = iss < n_reg;
        mem_tag.last = (iss == n_reg - CNT_W'(1));
        mem_tag.idx  = ncf_pkg::TAG_IDX_W'(iss[IDX_W-1:0]);
        if (dist_tag.vld && (stop || dist_tag.last)) begin
          // drop reads still in flight
          flush      = 1'b1;
          state_next = ncf_pkg::ST_RESULT;
        end
      end
      ncf_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ncf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ncf_pkg::ST_IDLE;
      end
    endcase
  end

  // Thresholds
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh[0] <= ncf_pkg::THRESH_D1_PRI_RST;
      thresh[1] <= ncf_pkg::THRESH_D1_SEC_RST;
      thresh[2] <= ncf_pkg::THRESH_D2_PRI_RST;
      thresh[3] <= ncf_pkg::THRESH_D2_SEC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ncf_pkg::REG_THRESH_D1_PRI: thresh[0] <= cfg_data;
        ncf_pkg::REG_THRESH_D1_SEC: thresh[1] <= cfg_data;
        ncf_pkg::REG_THRESH_D2_PRI: thresh[2] <= cfg_data;
        ncf_pkg::REG_THRESH_D2_SEC: thresh[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Group bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < ncf_pkg::NUM_GROUPS; g++) begin
        count[g]    <= '0;
        last_idx[g] <= '0;
        last_vld[g] <= 1'b0;
      end
    end else begin
      if (accept) begin
        case (ncf_pkg::cmd_t'(in_cmd))
          ncf_pkg::CMD_APPEND: begin
            if (!in_full) begin
              count[in_group] <= count[in_group] + CNT_W'(1);
            end
          end
          ncf_pkg::CMD_CLEAR: begin
            count[in_group]    <= '0;
            last_idx[in_group] <= '0;
            last_vld[in_group] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if ((state == ncf_pkg::ST_SCAN) && dist_tag.vld && (stop || dist_tag.last)) begin
        last_idx[grp] <= idx_final;
        last_vld[grp] <= 1'b1;
      end
    end
  end

  // Per-request working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      grp      <= in_group;
      n_reg    <= count[in_group];
      px       <= in_x;
      py       <= in_y;
      pz       <= in_z;
      iss      <= '0;
      have     <= 1'b0;
      best     <= '0;
      idx_r    <= '0;
      cached_r <= 1'b0;
      case (ncf_pkg::cmd_t'(in_cmd))
        ncf_pkg::CMD_APPEND: status_r <= in_full ? ncf_pkg::STATUS_FULL : ncf_pkg::STATUS_DONE;
        ncf_pkg::CMD_QUERY: begin
          status_r <= (count[in_group] == '0) ? ncf_pkg::STATUS_EMPTY : ncf_pkg::STATUS_FOUND;
        end
        default: status_r <= ncf_pkg::STATUS_DONE;
      endcase
    end
    if ((state == ncf_pkg::ST_CHK_WAIT) && dist_tag.vld && chk_ok) begin
      idx_r    <= last_idx[grp];
      cached_r <= 1'b1;
    end
    if (state == ncf_pkg::ST_SCAN) begin
      if (mem_re) begin
        iss <= iss + CNT_W'(1);
      end
      if (dist_tag.vld && better) begin
        idx_r <= tag_idx;
        if (!stop) begin
          best <= sq_dist;
          have <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    idx_wide        = {{OUT_IDX_PAD{1'b0}}, idx_r};
    res.status      = status_r;
    res.entry_index = idx_wide[ncf_pkg::OUT_IDX_W-1:0];
    res.from_cache  = cached_r | finish;
  end

endmodule

### rtl/nearest_centre_finder_cached.sv
// Top level: stream ports, output register and the centre store datapath.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser: command; tdata: group, x, y, z
//  m_*      | out       | m_tvalid/m_tready  | tuser: status; tdata: entry_index, from_cache
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data (threshold)
//
//  Append, clear and a query on an empty group go straight to the result state.
//  A query whose remembered entry is accepted reads and checks only that entry;
//  otherwise a scan follows, its length set by the group's count n and by the one
//  read per cycle of the centre memory and its registered read and distance pipeline.
//  rst is synchronous; counts and remembered entries clear at once, no memory sweep.
//  A result waits in the output register while the next request is already taken.

module nearest_centre_finder_cached #(
  parameter int ENTRIES_PER_GROUP = 64,
  parameter int COORD_BITS        = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ncf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ncf_pkg::THRESH_W-1:0]          cfg_data,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // group[2:0], point_x, point_y, point_z, zero pad
  input  logic [((3+3*COORD_BITS+7)/8)*8-1:0]   s_tdata,
  // command[1:0]
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // entry_index[5:0], from_cache[6], zero pad[7]
  output logic [ncf_pkg::OUT_DATA_W-1:0]        m_tdata,
  // status[1:0]
  output logic [1:0]                            m_tuser
);

  localparam int DEPTH  = 8 * ENTRIES_PER_GROUP;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = COORD_BITS;

  logic                  mem_we, mem_re, flush;
  logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
  logic [3*CW-1:0]       mem_wdata, mem_rdata;
  ncf_pkg::rd_tag_t      mem_tag, rd_tag, dist_tag;
  logic signed [CW-1:0]  px, py, pz;
  logic [2*CW+3:0]       sq_dist;
  logic                  res_valid, res_ready;
  ncf_pkg::result_t      res;

  ncf_ctrl #(
    .ENTRIES_PER_GROUP(ENTRIES_PER_GROUP),
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser),
    .in_group  (s_tdata[2:0]),
    .in_x      (s_tdata[3+CW-1:3]),
    .in_y      (s_tdata[3+2*CW-1:3+CW]),
    .in_z      (s_tdata[3+3*CW-1:3+2*CW]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_tag   (mem_tag),
    .flush     (flush),
    .px        (px),
    .py        (py),
    .pz        (pz),
    .sq_dist   (sq_dist),
    .dist_tag  (dist_tag),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ncf_centre_mem #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W),
    .DATA_W(3 * CW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr  (mem_raddr),
    .tag_in (mem_tag),
    .flush  (flush),
    .rdata  (mem_rdata),
    .tag_out(rd_tag)
  );

  ncf_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk    (clk),
    .rst    (rst),
    .centre (mem_rdata),
    .px     (px),
    .py     (py),
    .pz     (pz),
    .tag_in (rd_tag),
    .flush  (flush),
    .sq_dist(sq_dist),
    .tag_out(dist_tag)
  );

  assign res_ready = !m_tvalid || m_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {1'b0, res.from_cache, res.entry_index};
      m_tuser <= res.status;
    end
  end

endmodule
